/* design/wsfr_pkg.sv */
// Package for the websocket frame receiver: phase, result kind and error codes,
// the result record and small opcode helpers.
// No dependencies.
`timescale 1ns / 1ps

package wsfr_pkg;

    // Default depth of the result queue (a power of two, at least 2).
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    // Width of the frame length limit register.
    localparam int unsigned MAX_LEN_W = 63;

    // Largest payload of a control frame.
    localparam logic [6:0] CTRL_MAX_LEN = 7'd125;

    // Seven-bit length codes that announce an extended length.
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Frame opcodes.
    localparam logic [3:0] OP_CONT   = 4'd0;
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    // Header parse phase.
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    // Kind of a result transaction.
    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_MSG_END = 3'd1,
        KIND_PING    = 3'd2,
        KIND_PONG    = 3'd3,
        KIND_CLOSE   = 3'd4,
        KIND_ERROR   = 3'd5,
        KIND_ABANDON = 3'd6
    } kind_t;

    // Error codes reported with an error result.
    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_BAD_OPCODE   = 3'd1,
        ERR_CTRL_TOO_BIG = 3'd2,
        ERR_CTRL_FRAG    = 3'd3,
        ERR_ORPHAN_CONT  = 3'd4,
        ERR_TOO_LONG     = 3'd5,
        ERR_MSG_OVERFLOW = 3'd6
    } err_t;

    // One result transaction.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [3:0] opcode;
        logic       last;
        err_t       error_code;
    } result_t;

    // Close, ping and pong are the control opcodes handled here.
    function automatic logic is_control(input logic [3:0] op);
        return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

    // Event kind given at the end of a control frame.
    function automatic kind_t event_kind(input logic [3:0] op);
        kind_t k;
        case (op)
            OP_PING: k = KIND_PING;
            OP_PONG: k = KIND_PONG;
            default: k = KIND_CLOSE;
        endcase
        return k;
    endfunction

    // Builds a result record.
    function automatic result_t make_result(input kind_t k, input logic [7:0] b,
                                            input logic [3:0] op, input logic lst,
                                            input err_t e);
        result_t r;
        r.kind       = k;
        r.data_byte  = b;
        r.opcode     = op;
        r.last       = lst;
        r.error_code = e;
        return r;
    endfunction

endpackage

/* design/wsfr_parser.sv */
// Frame parser: input byte register, header and payload state, and the
// logic that turns one byte into zero, one or two results.
// Depends on wsfr_pkg.
`timescale 1ns / 1ps

module wsfr_parser
    import wsfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic [MAX_LEN_W-1:0] max_frame_length,
    input  logic                 out_room,
    output logic [1:0]           push_cnt,
    output result_t [1:0]        push_data
);

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       fire;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [3:0]  hidx_reg, hidx_next;
    logic [3:0]  frame_op_reg, frame_op_next;
    logic        frame_final_reg, frame_final_next;
    logic        frame_masked_reg, frame_masked_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  mask_idx_reg, mask_idx_next;
    logic [63:0] remain_reg, remain_next;
    logic [3:0]  open_op_reg, open_op_next;
    logic [63:0] msg_len_reg, msg_len_next;
    logic        skip_reg, skip_next;
    logic [3:0]  hdr_total_reg, hdr_total_next;

    // The byte in the input register is processed when the queue has room for two results.
    assign fire          = in_valid_reg && out_room;
    assign in_ready      = !in_valid_reg || out_room;
    assign in_valid_next = in_ready ? in_valid : in_valid_reg;

    // Next state and results for the registered byte.
    always_comb begin
        logic [7:0]  b;
        logic [7:0]  pb;
        logic [7:0]  key_byte;
        logic        finish;
        logic        done;
        logic        too_long;
        logic        overflow;
        logic [64:0] frame_total;
        logic [64:0] msg_sum;
        err_t        err;
        logic [1:0]  n;
        result_t     res [2];

        b        = in_byte_reg;
        pb       = '0;
        key_byte = '0;
        finish   = 1'b0;
        done     = 1'b0;
        overflow = 1'b0;
        err      = ERR_NONE;
        n        = '0;
        res[0]   = '0;
        res[1]   = '0;

        phase_next        = phase_reg;
        hidx_next         = hidx_reg;
        frame_op_next     = frame_op_reg;
        frame_final_next  = frame_final_reg;
        frame_masked_next = frame_masked_reg;
        len_next          = len_reg;
        key_next          = key_reg;
        mask_idx_next     = mask_idx_reg;
        remain_next       = remain_reg;
        open_op_next      = open_op_reg;
        msg_len_next      = msg_len_reg;
        skip_next         = skip_reg;
        hdr_total_next    = hdr_total_reg;

        // Per-phase byte handling.
        unique case (phase_reg)
            PH_FIRST: begin
                frame_final_next = b[7];
                frame_op_next    = b[3:0];
                hdr_total_next   = 4'd1;
                phase_next       = PH_SECOND;
            end
            PH_SECOND: begin
                frame_masked_next = b[7];
                hdr_total_next    = 4'd2;
                key_next          = '0;
                if (b[6:0] == LEN_CODE_EXT16 || b[6:0] == LEN_CODE_EXT64) begin
                    len_next   = '0;
                    hidx_next  = (b[6:0] == LEN_CODE_EXT16) ? 4'd2 : 4'd8;
                    phase_next = PH_EXTLEN;
                end else begin
                    len_next = {57'd0, b[6:0]};
                    if (b[7]) begin
                        hidx_next  = 4'd4;
                        phase_next = PH_KEY;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            PH_EXTLEN: begin
                len_next       = {len_reg[55:0], b};
                hdr_total_next = hdr_total_reg + 4'd1;
                hidx_next      = hidx_reg - 4'd1;
                if (hidx_next == 4'd0) begin
                    if (frame_masked_reg) begin
                        hidx_next  = 4'd4;
                        phase_next = PH_KEY;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            PH_KEY: begin
                key_next       = {key_reg[23:0], b};
                hdr_total_next = hdr_total_reg + 4'd1;
                hidx_next      = hidx_reg - 4'd1;
                if (hidx_next == 4'd0) begin
                    finish = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                // Key byte 0 is the first key byte received.
                case (mask_idx_reg)
                    2'd0:    key_byte = key_reg[31:24];
                    2'd1:    key_byte = key_reg[23:16];
                    2'd2:    key_byte = key_reg[15:8];
                    default: key_byte = key_reg[7:0];
                endcase
                pb            = frame_masked_reg ? (b ^ key_byte) : b;
                mask_idx_next = mask_idx_reg + 2'd1;
                remain_next   = remain_reg - 64'd1;
                done          = (remain_next == 64'd0);
                if (done) begin
                    phase_next = PH_FIRST;
                end
                if (skip_reg) begin
                    if (done) begin
                        skip_next = 1'b0;
                    end
                end else if (is_control(frame_op_reg)) begin
                    if (done) begin
                        res[n[0]] = make_result(event_kind(frame_op_reg), 8'd0,
                                                frame_op_reg, 1'b0, ERR_NONE);
                        n = n + 2'd1;
                    end
                end else begin
                    res[n[0]] = make_result(KIND_DATA, pb, open_op_reg,
                                            done && frame_final_reg, ERR_NONE);
                    n = n + 2'd1;
                    if (done && frame_final_reg) begin
                        open_op_next = OP_CONT;
                        msg_len_next = '0;
                    end
                end
            end
            default: begin
                phase_next = PH_FIRST;
            end
        endcase

        // Header end: length limit, message bookkeeping and frame checks.
        frame_total = {1'b0, len_next} + {61'd0, hdr_total_next};
        too_long    = frame_total > {2'b00, max_frame_length};
        msg_sum     = {1'b0, msg_len_reg} + {1'b0, len_next};
        if (finish) begin
            if (too_long) begin
                err = ERR_TOO_LONG;
            end else if (frame_op_reg != OP_CONT) begin
                // Any new opcode gives up a message that is still open.
                if (open_op_reg != OP_CONT) begin
                    res[n[0]] = make_result(KIND_ABANDON, 8'd0, open_op_reg, 1'b0,
                                            ERR_NONE);
                    n = n + 2'd1;
                    open_op_next = OP_CONT;
                    msg_len_next = '0;
                end
                if (is_control(frame_op_reg)) begin
                    if (len_next > {57'd0, CTRL_MAX_LEN}) begin
                        err = ERR_CTRL_TOO_BIG;
                    end else if (!frame_final_reg) begin
                        err = ERR_CTRL_FRAG;
                    end
                end else if (frame_op_reg == OP_TEXT || frame_op_reg == OP_BINARY) begin
                    open_op_next = frame_op_reg;
                    msg_len_next = len_next;
                end else begin
                    err = ERR_BAD_OPCODE;
                end
            end else if (open_op_reg == OP_CONT) begin
                err = ERR_ORPHAN_CONT;
            end else if (msg_sum[64]) begin
                // Message length overflow: error, then the message is given up.
                overflow  = 1'b1;
                res[n[0]] = make_result(KIND_ERROR, 8'd0, frame_op_reg, 1'b0,
                                        ERR_MSG_OVERFLOW);
                n = n + 2'd1;
                res[n[0]] = make_result(KIND_ABANDON, 8'd0, open_op_reg, 1'b0,
                                        ERR_NONE);
                n = n + 2'd1;
                open_op_next  = OP_CONT;
                msg_len_next  = '0;
                skip_next     = (len_next != 64'd0);
                phase_next    = (len_next != 64'd0) ? PH_PAYLOAD : PH_FIRST;
                remain_next   = len_next;
                mask_idx_next = '0;
            end else begin
                msg_len_next = msg_sum[63:0];
            end

            if (!overflow) begin
                mask_idx_next = '0;
                remain_next   = len_next;
                if (err != ERR_NONE) begin
                    res[n[0]] = make_result(KIND_ERROR, 8'd0, frame_op_reg, 1'b0, err);
                    n = n + 2'd1;
                    skip_next  = (len_next != 64'd0);
                    phase_next = (len_next != 64'd0) ? PH_PAYLOAD : PH_FIRST;
                end else if (len_next != 64'd0) begin
                    phase_next = PH_PAYLOAD;
                end else begin
                    // Empty frame: control event or end of message at once.
                    phase_next = PH_FIRST;
                    if (is_control(frame_op_reg)) begin
                        res[n[0]] = make_result(event_kind(frame_op_reg), 8'd0,
                                                frame_op_reg, 1'b0, ERR_NONE);
                        n = n + 2'd1;
                    end else if (frame_final_reg) begin
                        res[n[0]] = make_result(KIND_MSG_END, 8'd0, open_op_next,
                                                1'b1, ERR_NONE);
                        n = n + 2'd1;
                        open_op_next = OP_CONT;
                        msg_len_next = '0;
                    end
                end
            end
        end

        push_cnt     = fire ? n : 2'd0;
        push_data[0] = res[0];
        push_data[1] = res[1];
    end

    // Input byte register; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_byte_reg <= in_byte;
        end
    end

    // Control and parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            phase_reg        <= PH_FIRST;
            hidx_reg         <= '0;
            frame_op_reg     <= '0;
            frame_final_reg  <= 1'b0;
            frame_masked_reg <= 1'b0;
            len_reg          <= '0;
            key_reg          <= '0;
            mask_idx_reg     <= '0;
            remain_reg       <= '0;
            open_op_reg      <= OP_CONT;
            msg_len_reg      <= '0;
            skip_reg         <= 1'b0;
            hdr_total_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (fire) begin
                phase_reg        <= phase_next;
                hidx_reg         <= hidx_next;
                frame_op_reg     <= frame_op_next;
                frame_final_reg  <= frame_final_next;
                frame_masked_reg <= frame_masked_next;
                len_reg          <= len_next;
                key_reg          <= key_next;
                mask_idx_reg     <= mask_idx_next;
                remain_reg       <= remain_next;
                open_op_reg      <= open_op_next;
                msg_len_reg      <= msg_len_next;
                skip_reg         <= skip_next;
                hdr_total_reg    <= hdr_total_next;
            end
        end
    end

endmodule

/* design/wsfr_out_queue.sv */
// Result queue: takes up to two results a cycle and hands out one per
// transaction on the master side.
// Depends on wsfr_pkg.
`timescale 1ns / 1ps

module wsfr_out_queue
    import wsfr_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    push_cnt,
    input  result_t [1:0] push_data,
    output logic          room,
    output logic          out_valid,
    input  logic          out_ready,
    output result_t       out_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    result_t         mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [PW-1:0]   wr_ptr_plus1;
    logic            pop;

    // Pointer and fill bookkeeping.
    assign pop          = (count_reg != '0) && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);
    assign wr_ptr_next  = wr_ptr_reg + PW'(push_cnt);
    assign rd_ptr_next  = pop ? (rd_ptr_reg + PW'(1)) : rd_ptr_reg;
    assign count_next   = count_reg + CW'(push_cnt) - CW'(pop);

    // Room for a whole two-result burst.
    assign room      = (count_reg <= CW'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];

    // Storage writes.
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_data[0];
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push_data[1];
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/websocket_frame_receiver_unit.sv */
// Top level of the websocket frame receiver.
// Depends on wsfr_pkg, wsfr_parser and wsfr_out_queue.
`timescale 1ns / 1ps
//
// Usage:
// The slave side takes the received stream one byte per transaction on
// s_tdata. The block parses each frame header, unmasks the payload and sends
// text and binary payload bytes, message ends, ping/pong/close events, errors
// and abandoned-message notices on the master side, one result per transaction.
// cfg_wr_en with cfg_wr_data sets the largest allowed header plus payload
// length of a frame; write it only while the block is idle.
// A result passes through the input byte register and then the result queue
// before it is valid on the master side.
// Throughput: one byte per cycle while the queue has room; a byte that closes
// a header can give two results, which leave over two master-side transactions.
// A result queue of QUEUE_DEPTH entries sits between the parser and the master
// side. s_tready stays high while the queue can take two more results, so a
// stalled receiver fills the queue and then holds off the sender.
// Reset (aresetn low, synchronous) empties the queue, returns the parser to the
// first header byte with no open message and sets the length limit to 2^63-1.

module websocket_frame_receiver_unit
    import wsfr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration.
    input  logic                 cfg_wr_en,
    input  logic [MAX_LEN_W-1:0] cfg_wr_data,
    // Received stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    // Results.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [7:0] data_byte, [11:8] message_opcode,
                                            // [14:12] error_code, [15] zero
    output logic                 m_tlast,   // last
    output logic [2:0]           m_tuser    // [2:0] kind
);

    logic [MAX_LEN_W-1:0] max_len_reg;
    logic                 room;
    logic [1:0]           push_cnt;
    result_t [1:0]        push_data;
    result_t              head;

    // Frame length limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= '1;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Header parser and payload unmasking.
    wsfr_parser u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_byte          (s_tdata),
        .max_frame_length (max_len_reg),
        .out_room         (room),
        .push_cnt         (push_cnt),
        .push_data        (push_data)
    );

    // Result queue toward the master side.
    wsfr_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push_data (push_data),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    // Pack the result fields onto the master-side ports.
    assign m_tdata = {1'b0, head.error_code, head.opcode, head.data_byte};
    assign m_tlast = head.last;
    assign m_tuser = head.kind;

endmodule
